>>> src/qrs_pkg.sv
package qrs_pkg;

    // root_status codes
    typedef logic [1:0] qrs_status_t;

    localparam qrs_status_t ST_OK      = 2'd0;
    localparam qrs_status_t ST_NO_ROOT = 2'd1;
    localparam qrs_status_t ST_A_ZERO  = 2'd2;

    // sign flags of the coefficients, carried with each request
    typedef struct packed {
        logic a_neg;
        logic b_pos;
        logic c_neg;
    } qrs_sign_t;

    // entries in the queue between classifier and solver
    localparam int QUEUE_DEPTH = 4;

endpackage

>>> src/qrs_coef_if.sv
interface qrs_coef_if #(
    parameter int DATA_WIDTH = 32
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] coef_a;
    logic signed [DATA_WIDTH-1:0] coef_b;
    logic signed [DATA_WIDTH-1:0] coef_c;

    modport source (output valid, output coef_a, output coef_b, output coef_c, input ready);
    modport sink   (input valid, input coef_a, input coef_b, input coef_c, output ready);
endinterface

>>> src/qrs_root_if.sv
interface qrs_root_if #(
    parameter int DATA_WIDTH = 32
);
    logic                         valid;
    logic                         ready;
    logic [1:0]                   root_status;
    logic signed [DATA_WIDTH-1:0] root_low;
    logic signed [DATA_WIDTH-1:0] root_high;

    modport source (output valid, output root_status, output root_low, output root_high,
                    input ready);
    modport sink   (input valid, input root_status, input root_low, input root_high,
                    output ready);
endinterface

>>> src/qrs_front.sv
module qrs_front #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                    clk,
    input  logic                    rst_n,
    qrs_coef_if.sink                coef,
    input  logic                    q_full,
    output logic                    push,
    output qrs_pkg::qrs_status_t    status,
    output logic [2*DATA_WIDTH:0]   disc,
    output logic [DATA_WIDTH-1:0]   ma,
    output logic [DATA_WIDTH-1:0]   mb,
    output logic [DATA_WIDTH-1:0]   mc,
    output qrs_pkg::qrs_sign_t      signs
);
    import qrs_pkg::*;

    localparam int DW  = DATA_WIDTH;
    localparam int WW  = 2 * DW + 2;
    localparam int DWD = 2 * DW + 1;

    logic en;

    // stage 1: magnitudes and sign flags
    logic              v1_reg, a_zero1_reg, c_nz1_reg;
    qrs_sign_t         signs1_reg, signs1_next;
    logic [DW-1:0]     ma1_reg, mb1_reg, mc1_reg;
    logic [DW-1:0]     ma1_next, mb1_next, mc1_next;

    // stage 2: products
    logic              v2_reg, a_zero2_reg, c_nz2_reg;
    qrs_sign_t         signs2_reg;
    logic [DW-1:0]     ma2_reg, mb2_reg, mc2_reg;
    logic [2*DW-1:0]   bb2_reg, ac2_reg, bb2_next, ac2_next;

    // stage 3: discriminant and class
    logic              v3_reg;
    qrs_status_t       status3_reg, status3_next;
    logic [DWD-1:0]    d3_reg, d3_next;
    logic [DW-1:0]     ma3_reg, mb3_reg, mc3_reg;
    qrs_sign_t         signs3_reg;

    logic [WW-1:0]     bbx, ac4, d_sum, d_diff;
    logic              opp;

    assign en         = !q_full;
    assign coef.ready = en;

    // stage 1 logic
    always_comb
    begin
        ma1_next = coef.coef_a[DW-1] ? (~coef.coef_a + 1'b1) : coef.coef_a;
        mb1_next = coef.coef_b[DW-1] ? (~coef.coef_b + 1'b1) : coef.coef_b;
        mc1_next = coef.coef_c[DW-1] ? (~coef.coef_c + 1'b1) : coef.coef_c;
        signs1_next.a_neg = coef.coef_a[DW-1];
        signs1_next.b_pos = !coef.coef_b[DW-1] && (coef.coef_b != '0);
        signs1_next.c_neg = coef.coef_c[DW-1];
    end

    // stage 2 logic
    assign bb2_next = mb1_reg * mb1_reg;
    assign ac2_next = ma1_reg * mc1_reg;

    // stage 3 logic: D = b*b - 4ac, exact
    assign opp    = (signs2_reg.a_neg != signs2_reg.c_neg) && c_nz2_reg;
    assign bbx    = WW'(bb2_reg);
    assign ac4    = {ac2_reg, 2'b00};
    assign d_sum  = bbx + ac4;
    assign d_diff = bbx - ac4;

    always_comb
    begin
        status3_next = ST_OK;
        d3_next      = '0;
        if (a_zero2_reg)
        begin
            status3_next = ST_A_ZERO;
        end
        else if (opp)
        begin
            d3_next = d_sum[DWD-1:0];
        end
        else if (bbx < ac4)
        begin
            status3_next = ST_NO_ROOT;
        end
        else
        begin
            d3_next = d_diff[DWD-1:0];
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= coef.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_zero1_reg <= (coef.coef_a == '0);
            c_nz1_reg   <= (coef.coef_c != '0);
            signs1_reg  <= signs1_next;
            ma1_reg     <= ma1_next;
            mb1_reg     <= mb1_next;
            mc1_reg     <= mc1_next;

            a_zero2_reg <= a_zero1_reg;
            c_nz2_reg   <= c_nz1_reg;
            signs2_reg  <= signs1_reg;
            ma2_reg     <= ma1_reg;
            mb2_reg     <= mb1_reg;
            mc2_reg     <= mc1_reg;
            bb2_reg     <= bb2_next;
            ac2_reg     <= ac2_next;

            status3_reg <= status3_next;
            d3_reg      <= d3_next;
            ma3_reg     <= ma2_reg;
            mb3_reg     <= mb2_reg;
            mc3_reg     <= mc2_reg;
            signs3_reg  <= signs2_reg;
        end
    end

    assign push   = v3_reg && en;
    assign status = status3_reg;
    assign disc   = d3_reg;
    assign ma     = ma3_reg;
    assign mb     = mb3_reg;
    assign mc     = mc3_reg;
    assign signs  = signs3_reg;

endmodule

>>> src/qrs_fifo.sv
module qrs_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             full,
    output logic             empty
);
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, rd_ptr_reg, wr_ptr_next, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];

    // pointer and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

>>> src/qrs_sqrt.sv
module qrs_sqrt #(
    parameter int DATA_WIDTH = 32,
    parameter int SIDE_W     = 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic [2*DATA_WIDTH:0] disc,
    input  logic [SIDE_W-1:0]     side_in,
    output logic [DATA_WIDTH:0]   root,
    output logic [SIDE_W-1:0]     side_out
);
    localparam int SW = DATA_WIDTH + 1;
    localparam int WW = 2 * SW;

    logic [WW-1:0]     rem_reg  [SW];
    logic [SW-1:0]     root_reg [SW];
    logic [SIDE_W-1:0] side_reg [SW];

    logic [SW-1:0]     s_reg, s_next;
    logic [SIDE_W-1:0] side_out_reg;

    // one root bit per stage, remainder kept as D - r*r
    for (genvar j = 0; j < SW; j++)
    begin : g_stage
        localparam int K = SW - 1 - j;

        logic [WW-1:0]     rem_in, trial, rem_next;
        logic [SW-1:0]     root_in, root_next;
        logic [SIDE_W-1:0] side_w;

        if (j == 0)
        begin : g_first
            assign rem_in  = WW'(disc);
            assign root_in = '0;
            assign side_w  = side_in;
        end
        else
        begin : g_next
            assign rem_in  = rem_reg[j-1];
            assign root_in = root_reg[j-1];
            assign side_w  = side_reg[j-1];
        end

        assign trial = (WW'(root_in) << (K + 1)) + (WW'(1) << (2 * K));

        always_comb
        begin
            rem_next  = rem_in;
            root_next = root_in;
            if (rem_in >= trial)
            begin
                rem_next  = rem_in - trial;
                root_next = root_in | (SW'(1) << K);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                side_reg[j] <= '0;
            end
            else if (en)
            begin
                side_reg[j] <= side_w;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j]  <= rem_next;
                root_reg[j] <= root_next;
            end
        end
    end

    // round to nearest: bump when D > r*r + r
    assign s_next = root_reg[SW-1] + SW'(rem_reg[SW-1] > WW'(root_reg[SW-1]));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_out_reg <= '0;
        end
        else if (en)
        begin
            side_out_reg <= side_reg[SW-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_reg <= s_next;
        end
    end

    assign root     = s_reg;
    assign side_out = side_out_reg;

endmodule

>>> src/qrs_div.sv
module qrs_div #(
    parameter int DATA_WIDTH = 32,
    parameter int NUM_W      = 52,
    parameter int DEN_W      = 34,
    parameter int SIDE_W     = 1
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic [NUM_W-1:0]             num2,
    input  logic [DEN_W-1:0]             den2,
    input  logic                         neg,
    input  logic [SIDE_W-1:0]            side_in,
    output logic signed [DATA_WIDTH-1:0] quot,
    output logic [SIDE_W-1:0]            side_out
);
    localparam int DW = DATA_WIDTH;
    localparam int HW = NUM_W - DW;
    localparam int CW = (HW > DEN_W) ? HW : DEN_W;

    // entry stage
    logic              ovf_e_reg, neg_e_reg, ovf_e_next;
    logic [DEN_W-1:0]  rem_e_reg, den_e_reg, rem_e_next;
    logic [DW-1:0]     low_e_reg;
    logic [SIDE_W-1:0] side_e_reg;

    // one quotient bit per stage
    logic [DEN_W-1:0]  rem_reg  [DW];
    logic [DEN_W-1:0]  den_reg  [DW];
    logic [DW-1:0]     low_reg  [DW];
    logic [DW-1:0]     q_reg    [DW];
    logic              neg_reg  [DW];
    logic              ovf_reg  [DW];
    logic [SIDE_W-1:0] side_reg [DW];

    // saturation stage
    logic [DW-1:0]     quot_reg, quot_next, q_fin;
    logic [SIDE_W-1:0] side_out_reg;
    logic              big;

    // a quotient that reaches 2^DW is caught from the high part at once
    assign ovf_e_next = (CW'(num2[NUM_W-1:DW]) >= CW'(den2));
    assign rem_e_next = ovf_e_next ? '0 : DEN_W'(num2[NUM_W-1:DW]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_e_reg <= '0;
        end
        else if (en)
        begin
            side_e_reg <= side_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ovf_e_reg <= ovf_e_next;
            neg_e_reg <= neg;
            rem_e_reg <= rem_e_next;
            den_e_reg <= den2;
            low_e_reg <= num2[DW-1:0];
        end
    end

    for (genvar i = 0; i < DW; i++)
    begin : g_stage
        localparam int B = DW - 1 - i;

        logic [DEN_W-1:0]  rem_in, den_in, rem_next;
        logic [DW-1:0]     low_in, q_in, q_next;
        logic              neg_in, ovf_in, ge;
        logic [DEN_W:0]    remx, diff;
        logic [SIDE_W-1:0] side_w;

        if (i == 0)
        begin : g_first
            assign rem_in = rem_e_reg;
            assign den_in = den_e_reg;
            assign low_in = low_e_reg;
            assign q_in   = '0;
            assign neg_in = neg_e_reg;
            assign ovf_in = ovf_e_reg;
            assign side_w = side_e_reg;
        end
        else
        begin : g_next
            assign rem_in = rem_reg[i-1];
            assign den_in = den_reg[i-1];
            assign low_in = low_reg[i-1];
            assign q_in   = q_reg[i-1];
            assign neg_in = neg_reg[i-1];
            assign ovf_in = ovf_reg[i-1];
            assign side_w = side_reg[i-1];
        end

        // restoring step
        assign remx     = {rem_in, low_in[B]};
        assign ge       = (remx >= {1'b0, den_in});
        assign diff     = remx - {1'b0, den_in};
        assign rem_next = ge ? diff[DEN_W-1:0] : remx[DEN_W-1:0];
        assign q_next   = q_in | (DW'(ge) << B);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                side_reg[i] <= '0;
            end
            else if (en)
            begin
                side_reg[i] <= side_w;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i] <= rem_next;
                den_reg[i] <= den_in;
                low_reg[i] <= low_in;
                q_reg[i]   <= q_next;
                neg_reg[i] <= neg_in;
                ovf_reg[i] <= ovf_in;
            end
        end
    end

    // apply sign and saturate to the signed range
    assign q_fin = q_reg[DW-1];
    assign big   = ovf_reg[DW-1] || q_fin[DW-1];

    always_comb
    begin
        if (neg_reg[DW-1])
        begin
            quot_next = big ? {1'b1, {(DW-1){1'b0}}} : (~q_fin + 1'b1);
        end
        else
        begin
            quot_next = big ? {1'b0, {(DW-1){1'b1}}} : q_fin;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_out_reg <= '0;
        end
        else if (en)
        begin
            side_out_reg <= side_reg[DW-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quot_reg <= quot_next;
        end
    end

    assign quot     = quot_reg;
    assign side_out = side_out_reg;

endmodule

>>> src/qrs_back.sv
module qrs_back #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    output logic                  q_pop,
    input  qrs_pkg::qrs_status_t  q_status,
    input  logic [2*DATA_WIDTH:0] q_disc,
    input  logic [DATA_WIDTH-1:0] q_ma,
    input  logic [DATA_WIDTH-1:0] q_mb,
    input  logic [DATA_WIDTH-1:0] q_mc,
    input  qrs_pkg::qrs_sign_t    q_signs,
    qrs_root_if.source            root
);
    import qrs_pkg::*;

    localparam int DW        = DATA_WIDTH;
    localparam int SW        = DW + 1;
    localparam int MQW       = DW + 2;
    localparam int SQ_SIDE_W = 3 * DW + 7;
    localparam int NUM1_W    = DW + FRAC_BITS + 4;
    localparam int DEN1_W    = DW + 2;
    localparam int NUM2_W    = DW + FRAC_BITS + 3;
    localparam int DEN2_W    = DW + 3;

    logic en;

    // square root
    logic [SQ_SIDE_W-1:0] sq_side_in, sq_side_out;
    logic [SW-1:0]        sq_root;
    logic                 sq_valid, sq_dzero;
    qrs_status_t          sq_status;
    qrs_sign_t            sq_signs;
    logic [DW-1:0]        sq_ma, sq_mb, sq_mc;

    // q = -(b + sgn(b)*s)/2, held as |2q|
    logic                 p_valid_reg, p_dzero_reg, p_neg1_reg, p_neg2_reg;
    qrs_status_t          p_status_reg;
    logic [MQW-1:0]       p_mq_reg;
    logic [DW-1:0]        p_ma_reg, p_mc_reg;

    // dividers
    logic [NUM1_W-1:0]    n1;
    logic [DEN1_W-1:0]    d1;
    logic [NUM2_W-1:0]    n2;
    logic [DEN2_W-1:0]    d2;
    logic signed [DW-1:0] x0, x1d, x1;
    logic [2:0]           d1_side;
    logic                 d1_valid, d2_dzero;
    qrs_status_t          d1_status;

    // output register
    logic                 out_valid_reg;
    qrs_status_t          out_status_reg, out_status_next;
    logic signed [DW-1:0] out_low_reg, out_high_reg, out_low_next, out_high_next;

    assign en    = !out_valid_reg || root.ready;
    assign q_pop = en && q_valid;

    assign sq_side_in = {q_valid, q_status, q_signs, q_ma, q_mb, q_mc, (q_disc == '0)};

    qrs_sqrt #(
        .DATA_WIDTH (DW),
        .SIDE_W     (SQ_SIDE_W)
    ) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .disc     (q_disc),
        .side_in  (sq_side_in),
        .root     (sq_root),
        .side_out (sq_side_out)
    );

    assign {sq_valid, sq_status, sq_signs, sq_ma, sq_mb, sq_mc, sq_dzero} = sq_side_out;

    // |2q| = |b| + s in both branches; 2q is negative exactly when b > 0
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            p_valid_reg <= sq_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_status_reg <= sq_status;
            p_dzero_reg  <= sq_dzero;
            p_neg1_reg   <= (sq_signs.b_pos != sq_signs.a_neg);
            p_neg2_reg   <= (sq_signs.c_neg != sq_signs.b_pos);
            p_mq_reg     <= MQW'(sq_mb) + MQW'(sq_root);
            p_ma_reg     <= sq_ma;
            p_mc_reg     <= sq_mc;
        end
    end

    // rounded quotients as floor((2n + d) / 2d)
    assign n1 = (NUM1_W'(p_mq_reg) << (FRAC_BITS + 1)) + NUM1_W'({p_ma_reg, 1'b0});
    assign d1 = {p_ma_reg, 2'b00};
    assign n2 = (NUM2_W'(p_mc_reg) << (FRAC_BITS + 2)) + NUM2_W'(p_mq_reg);
    assign d2 = {p_mq_reg, 1'b0};

    // root q/a
    qrs_div #(
        .DATA_WIDTH (DW),
        .NUM_W      (NUM1_W),
        .DEN_W      (DEN1_W),
        .SIDE_W     (3)
    ) u_div_qa (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .num2     (n1),
        .den2     (d1),
        .neg      (p_neg1_reg),
        .side_in  ({p_valid_reg, p_status_reg}),
        .quot     (x0),
        .side_out (d1_side)
    );

    // root c/q
    qrs_div #(
        .DATA_WIDTH (DW),
        .NUM_W      (NUM2_W),
        .DEN_W      (DEN2_W),
        .SIDE_W     (1)
    ) u_div_cq (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .num2     (n2),
        .den2     (d2),
        .neg      (p_neg2_reg),
        .side_in  (p_dzero_reg),
        .quot     (x1d),
        .side_out (d2_dzero)
    );

    assign {d1_valid, d1_status} = d1_side;

    // double root takes -b/2a twice; then order the pair
    assign x1 = d2_dzero ? x0 : x1d;

    always_comb
    begin
        out_status_next = d1_status;
        out_low_next    = '0;
        out_high_next   = '0;
        if (d1_status == ST_OK)
        begin
            out_low_next  = (x0 > x1) ? x1 : x0;
            out_high_next = (x0 > x1) ? x0 : x1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= d1_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_status_reg <= out_status_next;
            out_low_reg    <= out_low_next;
            out_high_reg   <= out_high_next;
        end
    end

    assign root.valid       = out_valid_reg;
    assign root.root_status = out_status_reg;
    assign root.root_low    = out_low_reg;
    assign root.root_high   = out_high_reg;

endmodule

>>> src/quadratic_root_solver.sv
// Quadratic root solver for a*x*x + b*x + c = 0, coefficients signed fixed point
// with FRAC_BITS fraction bits.
// Channels: coef takes one request of coef_a, coef_b, coef_c; root returns one
// result per request, in order: root_status (ok, no real root, a is zero) and
// the two roots in ascending order, saturated, zero unless status is ok.
// Throughput: one request per cycle while coef.ready is high. Classification
// (magnitudes, products, discriminant) runs in 3 stages, then a 4-entry queue,
// then the solver: one square root bit per stage (DATA_WIDTH+1 stages plus
// rounding), one stage for q, and two dividers side by side at one quotient bit
// per stage (DATA_WIDTH+2 stages), then the output register.
// Reset clears all valid state; no result is shown after reset until a request
// has gone through.
// While a result waits with root.ready low the solver pipeline holds; the
// classifier takes requests until the queue is full, then coef.ready drops.
module quadratic_root_solver #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    qrs_coef_if.sink   coef,
    qrs_root_if.source root
);
    import qrs_pkg::*;

    localparam int DW     = DATA_WIDTH;
    localparam int DWD    = 2 * DW + 1;
    localparam int ITEM_W = 2 + DWD + 3 * DW + 3;

    logic              push, pop, q_full, q_empty;
    qrs_status_t       f_status, q_status;
    logic [DWD-1:0]    f_disc, q_disc;
    logic [DW-1:0]     f_ma, f_mb, f_mc, q_ma, q_mb, q_mc;
    qrs_sign_t         f_signs, q_signs;
    logic [ITEM_W-1:0] q_rd;

    qrs_front #(
        .DATA_WIDTH (DW)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .coef   (coef),
        .q_full (q_full),
        .push   (push),
        .status (f_status),
        .disc   (f_disc),
        .ma     (f_ma),
        .mb     (f_mb),
        .mc     (f_mc),
        .signs  (f_signs)
    );

    qrs_fifo #(
        .WIDTH (ITEM_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data ({f_status, f_disc, f_ma, f_mb, f_mc, f_signs}),
        .pop     (pop),
        .rd_data (q_rd),
        .full    (q_full),
        .empty   (q_empty)
    );

    assign {q_status, q_disc, q_ma, q_mb, q_mc, q_signs} = q_rd;

    qrs_back #(
        .DATA_WIDTH (DW),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (!q_empty),
        .q_pop    (pop),
        .q_status (q_status),
        .q_disc   (q_disc),
        .q_ma     (q_ma),
        .q_mb     (q_mb),
        .q_mc     (q_mc),
        .q_signs  (q_signs),
        .root     (root)
    );

endmodule

>>> src/qrs_check.sv
module qrs_check #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         out_valid,
    input  logic                         out_ready,
    input  logic [1:0]                   root_status,
    input  logic signed [DATA_WIDTH-1:0] root_low,
    input  logic signed [DATA_WIDTH-1:0] root_high
);
    import qrs_pkg::*;

    // a stalled result stays offered
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result withdrawn while stalled");

    // and does not change
    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(root_status) && $stable(root_low)
                                    && $stable(root_high))
        else $error("result changed while stalled");

    // roots come out ordered
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && root_status == ST_OK |-> root_low <= root_high)
        else $error("roots out of order");

    // no roots reported unless solved
    a_zero_fail: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && root_status != ST_OK |-> root_low == '0 && root_high == '0)
        else $error("roots not cleared on failure status");

endmodule

bind quadratic_root_solver qrs_check #(
    .DATA_WIDTH (DATA_WIDTH)
) u_qrs_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (root.valid),
    .out_ready   (root.ready),
    .root_status (root.root_status),
    .root_low    (root.root_low),
    .root_high   (root.root_high)
);

>>> tb/sv/tb_quadratic_root_solver.sv
module tb_quadratic_root_solver;

    timeunit 1ns;
    timeprecision 1ps;

    import qrs_pkg::*;

    localparam int DW = 32;
    localparam int FB = 16;
    localparam int LATENCY = 2 * DW + 10;

    typedef struct packed {
        qrs_status_t     status;
        logic [DW-1:0]   lo;
        logic [DW-1:0]   hi;
    } roots_t;

    logic clk;
    logic rst_n;
    int   send_idle_pct;
    int   recv_idle_pct;
    int   n_errors;
    roots_t expected_roots[$];

    qrs_coef_if #(.DATA_WIDTH(DW)) coef_ch ();
    qrs_root_if #(.DATA_WIDTH(DW)) root_ch ();

    quadratic_root_solver #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .coef  (coef_ch.sink),
        .root  (root_ch.source)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // round(num/den), ties away from zero; den of zero gives all ones
    function automatic logic [127:0] div_round(logic [127:0] num, logic [127:0] den);
        if (den == 0)
            return '1;
        return ((num << 1) + den) / (den << 1);
    endfunction

    // signed, saturated (+-mag * 2^sh) / den
    function automatic logic signed [63:0] sat_root(logic neg, logic [63:0] mag, int sh,
                                                    logic [63:0] den);
        logic [127:0] q;
        logic [127:0] lim;
        q   = div_round({64'd0, mag} << sh, {64'd0, den});
        lim = (128'd1 << (DW - 1)) - 1;
        if (neg)
            return (q > lim) ? -(64'sd1 <<< (DW - 1)) : -$signed(q[63:0]);
        return (q > lim) ? $signed(lim[63:0]) : $signed(q[63:0]);
    endfunction

    // square root rounded to nearest, half up
    function automatic logic [63:0] sqrt_round(logic [127:0] d);
        logic [63:0] r;
        logic [63:0] t;
        r = 0;
        for (int k = 63; k >= 0; k--)
        begin
            t = r | (64'd1 << k);
            if ({64'd0, t} * {64'd0, t} <= d)
                r = t;
        end
        if (d > {64'd0, r} * {64'd0, r} + {64'd0, r})
            r++;
        return r;
    endfunction

    function automatic roots_t predict_roots(logic signed [DW-1:0] a,
                                             logic signed [DW-1:0] b,
                                             logic signed [DW-1:0] c);
        roots_t res;
        logic [63:0] ma, mb, mc, mq;
        logic [127:0] bb, ac4, d;
        logic signed [63:0] x0, x1, t, s, q2, bs;
        res = '0;
        if (a == 0)
        begin
            res.status = ST_A_ZERO;
            return res;
        end
        ma  = (a < 0) ? -64'(a) : 64'(a);
        mb  = (b < 0) ? -64'(b) : 64'(b);
        mc  = (c < 0) ? -64'(c) : 64'(c);
        bb  = {64'd0, mb} * {64'd0, mb};
        ac4 = ({64'd0, ma} * {64'd0, mc}) << 2;
        if ((a < 0) != (c < 0) && c != 0)
            d = bb + ac4;
        else if (bb < ac4)
        begin
            res.status = ST_NO_ROOT;
            return res;
        end
        else
            d = bb - ac4;
        if (d == 0)
        begin
            x0 = sat_root((b > 0) != (a < 0), mb, FB, ma << 1);
            x1 = x0;
        end
        else
        begin
            s  = $signed(sqrt_round(d));
            bs = 64'(b);
            q2 = (b > 0) ? -(bs + s) : s - bs;
            mq = (q2 < 0) ? -q2 : q2;
            x0 = sat_root((q2 < 0) != (a < 0), mq, FB, ma << 1);
            x1 = sat_root((c < 0) != (q2 < 0), mc, FB + 1, mq);
        end
        if (x0 > x1)
        begin
            t  = x0;
            x0 = x1;
            x1 = t;
        end
        res.status = ST_OK;
        res.lo     = x0[DW-1:0];
        res.hi     = x1[DW-1:0];
        return res;
    endfunction

    // send one request, with random idle cycles before it; valid stays up afterwards
    task automatic send_coefs(logic [DW-1:0] a, logic [DW-1:0] b, logic [DW-1:0] c);
        while ($urandom_range(99) < send_idle_pct)
        begin
            coef_ch.valid <= 1'b0;
            @(posedge clk);
        end
        coef_ch.valid  <= 1'b1;
        coef_ch.coef_a <= a;
        coef_ch.coef_b <= b;
        coef_ch.coef_c <= c;
        @(posedge clk);
        while (!coef_ch.ready)
            @(posedge clk);
        expected_roots.push_back(predict_roots(a, b, c));
    endtask

    // receiver stall pattern
    always @(posedge clk)
        root_ch.ready <= ($urandom_range(99) >= recv_idle_pct);

    // compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin
        roots_t want;
        if (rst_n && root_ch.valid && root_ch.ready)
        begin
            if (expected_roots.size() == 0)
            begin
                $display("%0t: unexpected result st=%0d lo=%h hi=%h", $time,
                         root_ch.root_status, root_ch.root_low, root_ch.root_high);
                n_errors++;
            end
            else
            begin
                want = expected_roots.pop_front();
                if (root_ch.root_status !== want.status)
                begin
                    $display("%0t: root_status expected %0d actual %0d", $time,
                             want.status, root_ch.root_status);
                    n_errors++;
                end
                if (root_ch.root_low !== want.lo)
                begin
                    $display("%0t: root_low expected %h actual %h", $time,
                             want.lo, root_ch.root_low);
                    n_errors++;
                end
                if (root_ch.root_high !== want.hi)
                begin
                    $display("%0t: root_high expected %h actual %h", $time,
                             want.hi, root_ch.root_high);
                    n_errors++;
                end
            end
        end
    end

    function automatic logic [DW-1:0] rand_word();
        case ($urandom_range(5))
            0: return $urandom_range(255) << FB;
            1: return -($urandom_range(255) << FB);
            2: return $urandom_range(15) << $urandom_range(28);
            3: return -($urandom_range(15) << $urandom_range(28));
            default: return $urandom;
        endcase
    endfunction

    // drop valid, then wait for every outstanding result
    task automatic wait_drained();
        coef_ch.valid <= 1'b0;
        while (expected_roots.size() != 0)
            @(posedge clk);
    endtask

    // field extremes and each special case
    task automatic test_directed();
        logic [DW-1:0] mx, mn, one;
        mx  = {1'b0, {(DW-1){1'b1}}};
        mn  = {1'b1, {(DW-1){1'b0}}};
        one = 1 << FB;
        send_coefs(0, one, one);                 // a zero
        send_coefs(0, mn, mx);
        send_coefs(one, 0, one);                 // negative discriminant
        send_coefs(one, 2 * one, one);           // double root
        send_coefs(-one, 2 * one, -one);
        send_coefs(one, 0, -4 * one);            // b zero
        send_coefs(one, -3 * one, 2 * one);
        send_coefs(one, 3 * one, 2 * one);
        send_coefs(one, one, 0);                 // c zero
        send_coefs(1, mx, 1);                    // root overflow
        send_coefs(1, mn, 1);
        send_coefs(mx, mx, mx);
        send_coefs(mn, mn, mn);
        send_coefs(mn, mx, mx);
        send_coefs(mx, mn, mn);
        send_coefs(1, 0, mn);
        send_coefs(-1, 0, mx);
        send_coefs('1, '1, '1);
        send_coefs(mx, 0, 0);
        send_coefs(mn, 0, 0);
    endtask

    // random coefficients
    task automatic test_random(int count);
        logic [DW-1:0] a, b, c;
        for (int i = 0; i < count; i++)
        begin
            a = rand_word();
            b = rand_word();
            c = rand_word();
            if ($urandom_range(3) == 0)
                c = -c;
            send_coefs(a, b, c);
        end
    endtask

    // sender holds off until the pipeline is empty
    task automatic test_drain_pause();
        test_random(10);
        wait_drained();
        test_random(10);
    endtask

    initial
    begin
        n_errors          = 0;
        send_idle_pct     = 35;
        recv_idle_pct     = 59;
        rst_n             = 1'b0;
        coef_ch.valid     = 1'b0;
        coef_ch.coef_a    = '0;
        coef_ch.coef_b    = '0;
        coef_ch.coef_c    = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(340);
        test_drain_pause();
        send_idle_pct = 59;
        recv_idle_pct = 35;
        test_random(360);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(360);
        wait_drained();
        repeat (LATENCY + 20) @(posedge clk);
        if (n_errors == 0 && expected_roots.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // watchdog
    initial
    begin
        #5ms;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
